// File: rtl/ptd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_pkg
// Types and codes shared by the periodic task dispatcher and its channels.
// ----------------------------------------------------------------------------
package ptd_pkg;

    // command kinds
    localparam logic [2:0] KIND_TICK    = 3'd0;
    localparam logic [2:0] KIND_CREATE  = 3'd1;
    localparam logic [2:0] KIND_SUSPEND = 3'd2;
    localparam logic [2:0] KIND_RESUME  = 3'd3;
    localparam logic [2:0] KIND_DELETE  = 3'd4;

    // result status
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_BUSY = 1'b1;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  slot;
        logic [15:0] period;
        logic [15:0] first_delay;
    } t_cmd;

    typedef struct packed {
        logic [7:0] fire_mask;
        logic       status;
    } t_res;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK,
        S_LAST,
        S_PUSH
    } t_state;

endpackage
`default_nettype wire

// File: rtl/ptd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptd_if
// Valid/ready channels for dispatcher commands and results.
// ----------------------------------------------------------------------------
interface ptd_cmd_if;
    logic          valid;
    logic          ready;
    ptd_pkg::t_cmd data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ptd_res_if;
    logic          valid;
    logic          ready;
    ptd_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/periodic_task_dispatcher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_task_dispatcher
// Time-triggered cooperative scheduler: a table of periodic task slots,
// stepped by tick commands.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries one command beat: tick, create, suspend, resume or delete,
//   with a slot number and, for create, a period and first delay. Every
//   command beat yields exactly one result beat on o_res: the fired-slot
//   mask (ticks only) and a status bit (create refused on a taken slot or
//   on a slot beyond the table).
//   One command is worked on at a time. Suspend, resume, delete, create and
//   unknown kinds go from acceptance straight to S_PUSH, which moves the
//   pending result into the result register; a tick first walks the
//   period/countdown memory through S_TICK and S_LAST: one read per cycle,
//   the write-back in the cycle after it on the single write port. The next
//   beat is accepted only once the state machine is back in S_IDLE.
//   Occupied and resumed flags live in flip-flops; period and countdown live
//   in a synchronous RAM with a registered read. Its contents only count
//   once a create has written the slot, so no clearing pass is needed.
//   Reset (synchronous, active low) clears all flags and the channels.
//   A result waits in the output register while o_res.ready is low; the next
//   command is still accepted and processed, and its result holds in a
//   pending register until the output register frees. Input stalls meanwhile.
// ----------------------------------------------------------------------------
module periodic_task_dispatcher #(
    parameter int TASK_SLOTS = 8
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ptd_cmd_if.sink    i_cmd,
    ptd_res_if.source  o_res
);
    import ptd_pkg::*;

    localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

    // state machine
    t_state r_state, n_state;

    // slot flags, cleared by reset
    logic [TASK_SLOTS-1:0] r_occ, n_occ;
    logic [TASK_SLOTS-1:0] r_resm, n_resm;

    // period/countdown RAM, {period, countdown} per entry
    logic [31:0] mem [TASK_SLOTS];
    logic [31:0] r_rd_data;
    logic        mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    logic [31:0] mem_wdata;

    // tick walk
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic              r_wb_valid;
    logic [SLOT_W-1:0] r_wb_idx;

    // pending result and output register
    t_res r_res, n_res;
    t_res r_out;
    logic r_ov;

    // command decode
    logic              accept;
    logic [5:0]        slot_ext;
    logic              slot_ok;
    logic [SLOT_W-1:0] slot_idx;
    logic              create_we;
    logic              out_load;

    assign accept   = i_cmd.valid && i_cmd.ready;
    assign slot_ext = {3'b000, i_cmd.data.slot};
    assign slot_ok  = slot_ext < 6'(TASK_SLOTS);
    assign slot_idx = slot_ext[SLOT_W-1:0];
    assign out_load = (r_state == S_PUSH) && (!r_ov || o_res.ready);

    // ---------------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_state = (i_cmd.data.kind == KIND_TICK) ? S_TICK : S_PUSH;
                end
            end
            S_TICK: begin
                if (r_idx == SLOT_W'(TASK_SLOTS - 1)) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: n_state = S_PUSH;
            S_PUSH: begin
                if (!r_ov || o_res.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- datapath
    always_comb begin
        logic [15:0] per;
        logic [15:0] cnt;
        logic        live;

        n_occ     = r_occ;
        n_resm    = r_resm;
        n_res     = r_res;
        n_idx     = r_idx;
        create_we = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_wb_idx;
        mem_wdata = r_rd_data;
        per       = r_rd_data[31:16];
        cnt       = r_rd_data[15:0];
        live      = r_occ[r_wb_idx] && r_resm[r_wb_idx];
        i_cmd.ready = (r_state == S_IDLE);

        if (accept) begin
            n_res = '{fire_mask: 8'h00, status: STATUS_OK};
            n_idx = '0;
            unique case (i_cmd.data.kind)
                KIND_TICK: ;
                KIND_CREATE: begin
                    if (slot_ok && !r_occ[slot_idx]) begin
                        n_occ[slot_idx]  = 1'b1;
                        n_resm[slot_idx] = 1'b1;
                        create_we        = 1'b1;
                    end else begin
                        n_res.status = STATUS_BUSY;
                    end
                end
                KIND_SUSPEND: if (slot_ok) n_resm[slot_idx] = 1'b0;
                KIND_RESUME:  if (slot_ok) n_resm[slot_idx] = 1'b1;
                KIND_DELETE:  if (slot_ok) n_occ[slot_idx]  = 1'b0;
                default: ;
            endcase
        end

        if (r_state == S_TICK) begin
            n_idx = r_idx + SLOT_W'(1);
        end

        if (create_we) begin
            mem_we    = 1'b1;
            mem_waddr = slot_idx;
            mem_wdata = {i_cmd.data.period, i_cmd.data.first_delay};
        end else if (r_wb_valid && live) begin
            mem_we = 1'b1;
            if (cnt == 16'h0000) begin
                // fire and reload; period zero wraps to 0xFFFF
                mem_wdata       = {per, per - 16'd1};
                n_res.fire_mask = r_res.fire_mask | (8'h01 << r_wb_idx);
            end else begin
                mem_wdata = {per, cnt - 16'd1};
            end
        end
    end

    // ---------------------------------------------------------------- memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (r_state == S_TICK) begin
            r_rd_data <= mem[r_idx];
        end
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_occ      <= '0;
            r_resm     <= '0;
            r_wb_valid <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_occ      <= n_occ;
            r_resm     <= n_resm;
            r_wb_valid <= (r_state == S_TICK);
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_wb_idx <= r_idx;
        r_res    <= n_res;
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_res.valid = r_ov;
    assign o_res.data  = r_out;

    // ---------------------------------------------------------------- checks
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(create_we && r_wb_valid))
        else $error("create write collides with tick write-back");

    a_wb_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_valid |-> (r_state == S_TICK || r_state == S_LAST))
        else $error("write-back outside tick walk");

    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("accepted command left no work");

    a_busy_no_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.data.status && (o_res.data.fire_mask != 8'h00)))
        else $error("refused create reports fired slots");

endmodule
`default_nettype wire
